// ===== hdl/gbfw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfw_pkg
// Shared types and constants for the grid breadth-first flood walker.
// ----------------------------------------------------------------------------
package gbfw_pkg;

    // Default grid limits for the top-level parameters
    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    // Payload and register widths
    localparam int COORD_W = 4;
    localparam int CFG_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Width of the visited-map generation tag
    localparam int EPOCH_W = 8;

    // Register reset values
    localparam logic [CFG_W-1:0] ROWS_RESET = 5'd10;
    localparam logic [CFG_W-1:0] COLS_RESET = 5'd10;

    // Register indexes (taken from address bit 2)
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Neighbour order: column+1, row+1, column-1, row-1
    localparam logic signed [1:0] NBR_DROW [4] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};
    localparam logic signed [1:0] NBR_DCOL [4] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0};

    typedef enum logic [2:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_WRAP_CLEAR,
        ST_NBR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic start_exec;
        logic step_empty;
        logic pop_load;
        logic nbr_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic item_op;
        logic queue_empty;
        logic epoch_full;
        logic clear_last;
        logic nbr_last;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/gbfw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/gbfw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfw_ctrl
// Sequencer: clearing passes, item dispatch, neighbour walk and result hand-off.
// ----------------------------------------------------------------------------
module gbfw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gbfw_pkg::status_t status,
    output gbfw_pkg::cmd_t    cmd
);

    import gbfw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (status.item_op == OP_START) begin
                    // tag space used up: wipe the map, then come back
                    if (status.epoch_full) begin
                        state_next = ST_WRAP_CLEAR;
                    end else begin
                        cmd.start_exec = 1'b1;
                        state_next     = ST_DONE;
                    end
                end else if (status.queue_empty) begin
                    cmd.step_empty = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    cmd.pop_load = 1'b1;
                    state_next   = ST_NBR;
                end
            end
            ST_WRAP_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_NBR: begin
                cmd.nbr_step = 1'b1;
                if (status.nbr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/gbfw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfw_dp
// Datapath: visited map, cell queue, neighbour pipeline and result register.
// ----------------------------------------------------------------------------
module gbfw_dp #(
    parameter int MAX_ROWS = gbfw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gbfw_pkg::MAX_COLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gbfw_pkg::cmd_t                cmd,
    output gbfw_pkg::status_t             status,
    input  logic                          s_op,
    input  logic [gbfw_pkg::COORD_W-1:0]  s_start_row,
    input  logic [gbfw_pkg::COORD_W-1:0]  s_start_col,
    input  logic [gbfw_pkg::CFG_W-1:0]    rows_eff,
    input  logic [gbfw_pkg::CFG_W-1:0]    cols_eff,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic                          m_visit_valid,
    output logic [gbfw_pkg::COORD_W-1:0]  m_visit_row,
    output logic [gbfw_pkg::COORD_W-1:0]  m_visit_col,
    output logic                          m_last,
    output logic                          m_error
);

    import gbfw_pkg::*;

    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int QPW        = CELL_AW + 1;
    // rows and columns never reach 31 because the size registers are 5 bits
    localparam int ROW_LIM    = (MAX_ROWS < 31) ? MAX_ROWS : 31;
    localparam int COL_LIM    = (MAX_COLS < 31) ? MAX_COLS : 31;
    localparam int ROW_W      = ($clog2(ROW_LIM) > COORD_W) ? $clog2(ROW_LIM) : COORD_W;
    localparam int COL_W      = ($clog2(COL_LIM) > COORD_W) ? $clog2(COL_LIM) : COORD_W;
    localparam int QW         = ROW_W + COL_W;

    // item registers
    logic               op_reg;
    logic [COORD_W-1:0] srow_reg;
    logic [COORD_W-1:0] scol_reg;

    // queue pointers, map tag, clear sweep
    logic [QPW-1:0]     head_reg;
    logic [QPW-1:0]     tail_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [CELL_AW-1:0] clr_reg;

    // popped cell and neighbour pipeline
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [2:0]         k_reg;
    logic               nb_valid_reg;
    logic [CELL_AW-1:0] nb_addr_reg;
    logic [ROW_W-1:0]   nb_row_reg;
    logic [COL_W-1:0]   nb_col_reg;

    // pending result
    logic               res_visit_reg;
    logic               res_error_reg;

    // output register
    logic               m_valid_reg;
    logic               m_visit_valid_reg;
    logic [COORD_W-1:0] m_visit_row_reg;
    logic [COORD_W-1:0] m_visit_col_reg;
    logic               m_last_reg;
    logic               m_error_reg;

    // memories
    logic               vis_we;
    logic [CELL_AW-1:0] vis_waddr;
    logic [EPOCH_W-1:0] vis_wdata;
    logic [EPOCH_W-1:0] vis_rdata;
    logic               q_we;
    logic [CELL_AW-1:0] q_waddr;
    logic [QW-1:0]      q_wdata;
    logic [QW-1:0]      q_rdata;

    // combinational helpers
    logic                    start_in;
    logic [CELL_AW-1:0]      start_addr;
    logic [1:0]              nb_idx;
    logic signed [ROW_W+1:0] rr_s;
    logic signed [COL_W+1:0] cc_s;
    logic [ROW_W+1:0]        rr_u;
    logic [COL_W+1:0]        cc_u;
    logic                    nb_in;
    logic [CELL_AW-1:0]      nb_addr;
    logic                    nb_push;
    logic                    q_empty;

    assign start_in   = ({1'b0, srow_reg} < rows_eff) && ({1'b0, scol_reg} < cols_eff);
    assign start_addr = CELL_AW'(32'(srow_reg) * MAX_COLS + 32'(scol_reg));

    assign nb_idx = k_reg[1:0];
    assign rr_s   = $signed({2'b00, row_reg}) + (ROW_W+2)'(NBR_DROW[nb_idx]);
    assign cc_s   = $signed({2'b00, col_reg}) + (COL_W+2)'(NBR_DCOL[nb_idx]);
    assign rr_u   = $unsigned(rr_s);
    assign cc_u   = $unsigned(cc_s);
    assign nb_in  = !rr_u[ROW_W+1] && !cc_u[COL_W+1]
                    && (rr_u < (ROW_W+2)'(rows_eff)) && (cc_u < (COL_W+2)'(cols_eff));
    assign nb_addr = CELL_AW'(32'(rr_u[ROW_W-1:0]) * MAX_COLS + 32'(cc_u[COL_W-1:0]));

    // neighbour read last cycle comes back now; unmarked in this generation -> push
    assign nb_push = cmd.nbr_step && nb_valid_reg && (vis_rdata != epoch_reg);
    assign q_empty = (head_reg == tail_reg);

    always_comb begin
        if (cmd.clear_step) begin
            vis_we    = 1'b1;
            vis_waddr = clr_reg;
            vis_wdata = '0;
        end else if (cmd.start_exec) begin
            vis_we    = start_in;
            vis_waddr = start_addr;
            vis_wdata = epoch_reg + 1'b1;
        end else begin
            vis_we    = nb_push;
            vis_waddr = nb_addr_reg;
            vis_wdata = epoch_reg;
        end
    end

    always_comb begin
        if (cmd.start_exec) begin
            q_we    = start_in;
            q_waddr = '0;
            q_wdata = {ROW_W'(srow_reg), COL_W'(scol_reg)};
        end else begin
            q_we    = nb_push;
            q_waddr = tail_reg[CELL_AW-1:0];
            q_wdata = {nb_row_reg, nb_col_reg};
        end
    end

    gbfw_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (CELL_COUNT)
    ) u_visited (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (nb_addr),
        .rdata (vis_rdata)
    );

    gbfw_ram #(
        .WIDTH (QW),
        .DEPTH (CELL_COUNT)
    ) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[CELL_AW-1:0]),
        .rdata (q_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            epoch_reg    <= EPOCH_W'(1);
            clr_reg      <= '0;
            k_reg        <= '0;
            nb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                if (status.clear_last) begin
                    clr_reg   <= '0;
                    epoch_reg <= EPOCH_W'(1);
                end else begin
                    clr_reg <= clr_reg + 1'b1;
                end
            end
            if (cmd.start_exec) begin
                head_reg  <= '0;
                tail_reg  <= start_in ? QPW'(1) : '0;
                epoch_reg <= epoch_reg + 1'b1;
            end
            if (cmd.pop_load) begin
                head_reg     <= head_reg + 1'b1;
                k_reg        <= '0;
                nb_valid_reg <= 1'b0;
            end
            if (cmd.nbr_step) begin
                k_reg        <= k_reg + 1'b1;
                nb_valid_reg <= !k_reg[2] && nb_in;
                if (nb_push) begin
                    tail_reg <= tail_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= s_op;
            srow_reg <= s_start_row;
            scol_reg <= s_start_col;
        end
        if (cmd.start_exec) begin
            res_visit_reg <= 1'b0;
            res_error_reg <= !start_in;
        end
        if (cmd.step_empty) begin
            res_visit_reg <= 1'b0;
            res_error_reg <= 1'b1;
        end
        if (cmd.pop_load) begin
            row_reg       <= q_rdata[QW-1:COL_W];
            col_reg       <= q_rdata[COL_W-1:0];
            res_visit_reg <= 1'b1;
            res_error_reg <= 1'b0;
        end
        if (cmd.nbr_step) begin
            nb_addr_reg <= nb_addr;
            nb_row_reg  <= rr_u[ROW_W-1:0];
            nb_col_reg  <= cc_u[COL_W-1:0];
        end
        if (cmd.out_load) begin
            m_visit_valid_reg <= res_visit_reg;
            m_visit_row_reg   <= res_visit_reg ? row_reg[COORD_W-1:0] : '0;
            m_visit_col_reg   <= res_visit_reg ? col_reg[COORD_W-1:0] : '0;
            m_last_reg        <= res_visit_reg && q_empty;
            m_error_reg       <= res_error_reg;
        end
    end

    assign status.item_op     = op_reg;
    assign status.queue_empty = q_empty;
    assign status.epoch_full  = (epoch_reg == '1);
    assign status.clear_last  = (clr_reg == CELL_AW'(CELL_COUNT - 1));
    assign status.nbr_last    = k_reg[2];
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_visit_valid = m_visit_valid_reg;
    assign m_visit_row   = m_visit_row_reg;
    assign m_visit_col   = m_visit_col_reg;
    assign m_last        = m_last_reg;
    assign m_error       = m_error_reg;

endmodule

// ===== hdl/grid_bfs_flood_walker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bfs_flood_walker_core
// Breadth-first flood walk over a rows-by-columns grid with four neighbours.
// ----------------------------------------------------------------------------
// A start beat (op 0) begins a new search at (start_row, start_col) and
// returns one result beat carrying only the error flag (start outside the
// grid). Each step beat (op 1) pops the oldest queued cell, returns it as the
// next visited cell, and marks and queues its unvisited in-grid neighbours in
// the order column+1, row+1, column-1, row-1; last is set when the queue is
// empty afterwards, and a step on an empty queue returns error. Items are
// worked one at a time; a step pops its cell, then makes one visited-map read
// per neighbour through the single read port of the map, overlapped with the
// mark of the previous neighbour. A new beat is accepted while a finished
// result still waits on the output register. The visited map stores a
// generation tag per cell, so a start does not wipe it; after reset, and
// when the tag space is used up (the 255th start after reset and every
// 254th start after that), a clearing pass over all MAX_ROWS*MAX_COLS cells
// (256 by default) runs with s_ready low.
// Grid size registers (APB, 0x0 rows, 0x4 columns) are clamped to the
// maximum and must be written while the block is idle.
// ----------------------------------------------------------------------------
module grid_bfs_flood_walker_core #(
    parameter int MAX_ROWS = gbfw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gbfw_pkg::MAX_COLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [gbfw_pkg::COORD_W-1:0]  s_start_row,
    input  logic [gbfw_pkg::COORD_W-1:0]  s_start_col,

    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_visit_valid,
    output logic [gbfw_pkg::COORD_W-1:0]  m_visit_row,
    output logic [gbfw_pkg::COORD_W-1:0]  m_visit_col,
    output logic                          m_last,
    output logic                          m_error,

    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gbfw_pkg::APB_AW-1:0]   paddr,
    input  logic [gbfw_pkg::APB_DW-1:0]   pwdata,
    output logic [gbfw_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import gbfw_pkg::*;

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_eff;
    logic [CFG_W-1:0] cols_eff;
    logic             cfg_wr;
    logic             reg_sel;
    cmd_t             cmd;
    status_t          status;

    // --- configuration registers --------------------------------------------
    // Byte-offset bits are ignored; address bit 2 picks the register.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_ROWS: rows_reg <= pwdata[CFG_W-1:0];
                REG_COLS: cols_reg <= pwdata[CFG_W-1:0];
                default: begin
                    rows_reg <= rows_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ROWS: prdata = APB_DW'(rows_reg);
            REG_COLS: prdata = APB_DW'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    // Sizes above the grid maximum act as the maximum; zero gives an empty grid.
    assign rows_eff = (32'(rows_reg) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : rows_reg;
    assign cols_eff = (32'(cols_reg) > MAX_COLS) ? CFG_W'(MAX_COLS) : cols_reg;

    // --- sequencer ----------------------------------------------------------
    gbfw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // --- datapath: map, queue, neighbour pipeline, result register ----------
    gbfw_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_op          (s_op),
        .s_start_row   (s_start_row),
        .s_start_col   (s_start_col),
        .rows_eff      (rows_eff),
        .cols_eff      (cols_eff),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_visit_valid (m_visit_valid),
        .m_visit_row   (m_visit_row),
        .m_visit_col   (m_visit_col),
        .m_last        (m_last),
        .m_error       (m_error)
    );

    // --- assertions ---------------------------------------------------------
    // Never overwrite a result that is still waiting.
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result loaded over a pending beat");

    // No input beat is taken while the map is being swept.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !s_ready)
        else $error("input accepted during clearing pass");

    // Datapath work commands are mutually exclusive.
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear_step, cmd.start_exec, cmd.step_empty,
                  cmd.pop_load, cmd.nbr_step, cmd.out_load}))
        else $error("overlapping datapath commands");

    // A flagged last visit is always a real visit, never an error, and an error beat carries no visit.
    a_last_is_visit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_last || m_error)) |-> (m_visit_valid != m_error))
        else $error("inconsistent result flags");

endmodule
